// ===== src/mfoc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfoc_pkg
// Types and constants shared by the face orthogonality check block.
// ----------------------------------------------------------------------------
package mfoc_pkg;

   localparam int NUM_BINS        = 9;
   localparam int BIN_BITS        = 4;
   localparam int FACE_COUNT_BITS = 24;
   localparam int CNT_BITS        = 25;
   localparam int SUM_BITS        = 40;
   localparam int COS_BITS        = 16;
   localparam int CSR_IDX_BITS    = 4;

   // result kinds
   localparam logic [1:0] KIND_FACE  = 2'd0;
   localparam logic [1:0] KIND_BIN   = 2'd1;
   localparam logic [1:0] KIND_TOTAL = 2'd2;

   // face classes
   localparam logic [1:0] CLASS_OK     = 2'd0;
   localparam logic [1:0] CLASS_SEVERE = 2'd1;
   localparam logic [1:0] CLASS_ERROR  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEVERE_THR = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ERROR_LVL  = 4'd1;

   localparam logic signed [COS_BITS-1:0] SEVERE_THR_RESET = 16'sd11207;
   localparam logic signed [COS_BITS-1:0] ERROR_LVL_RESET  = 16'sd0;
   localparam logic signed [COS_BITS-1:0] COS_MAX          = 16'sd32767;

   // bin edges: cos(10 i degrees) in Q1.15, cos 0 held at full scale
   localparam logic signed [COS_BITS-1:0] BIN_EDGE [0:18] = '{
      16'sd32767, 16'sd32270, 16'sd30792, 16'sd28378, 16'sd25102, 16'sd21063,
      16'sd16384, 16'sd11207, 16'sd5690, 16'sd0, -16'sd5690, -16'sd11207,
      -16'sd16384, -16'sd21063, -16'sd25102, -16'sd28378, -16'sd30792,
      -16'sd32270, -16'sd32768
   };

   typedef struct packed {
      logic signed [31:0] owner_x;
      logic signed [31:0] owner_y;
      logic signed [31:0] owner_z;
      logic signed [31:0] neighbour_x;
      logic signed [31:0] neighbour_y;
      logic signed [31:0] neighbour_z;
      logic signed [31:0] area_x;
      logic signed [31:0] area_y;
      logic signed [31:0] area_z;
      logic               last_face;
   } mfoc_req_type;

   typedef struct packed {
      logic [1:0]                 result_kind;
      logic [FACE_COUNT_BITS-1:0] item_index;
      logic signed [COS_BITS-1:0] cosine;
      logic [BIN_BITS-1:0]        bin_number;
      logic [1:0]                 face_class;
      logic [CNT_BITS-1:0]        count;
      logic signed [COS_BITS-1:0] min_cosine;
      logic signed [SUM_BITS-1:0] sum_cosine;
      logic [CNT_BITS-1:0]        severe_count;
      logic [CNT_BITS-1:0]        error_count;
      logic                       any_error;
      logic                       last_result;
   } mfoc_rsp_type;

   typedef struct packed {
      logic [CNT_BITS-1:0]        face_count;
      logic signed [COS_BITS-1:0] min_cosine;
      logic signed [SUM_BITS-1:0] sum_cosine;
      logic [CNT_BITS-1:0]        severe_count;
      logic [CNT_BITS-1:0]        error_count;
   } mfoc_totals_type;

endpackage

// ===== src/mfoc_cosine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfoc_cosine
// Sequenced cosine unit: scale, shared multiplier, square root and divide.
// ----------------------------------------------------------------------------
module mfoc_cosine
   import mfoc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  mfoc_req_type               req,
   output logic                       done,
   output logic signed [COS_BITS-1:0] cosine
);

   localparam logic [3:0] C_IDLE  = 4'd0;
   localparam logic [3:0] C_MAX   = 4'd1;
   localparam logic [3:0] C_SCALE = 4'd2;
   localparam logic [3:0] C_MUL   = 4'd3;
   localparam logic [3:0] C_ACC   = 4'd4;
   localparam logic [3:0] C_SQRT  = 4'd5;
   localparam logic [3:0] C_DEN   = 4'd6;
   localparam logic [3:0] C_DIVI  = 4'd7;
   localparam logic [3:0] C_DIV   = 4'd8;
   localparam logic [3:0] C_DONE  = 4'd9;

   localparam logic [43:0] SQRT_TOP = 44'h400_0000_0000;

   logic [3:0]         state_ff, state_in;
   logic signed [33:0] dv_ff [3], dv_in [3];
   logic signed [33:0] sv_ff [3], sv_in [3];
   logic [32:0]        md_ff, md_in, ms_ff, ms_in;
   logic [1:0]         phase_ff, phase_in, lane_ff, lane_in;
   logic signed [43:0] prod_ff, prod_in;
   logic signed [43:0] dot_ff, dot_in;
   logic [43:0]        dd_ff, dd_in, ss_ff, ss_in;
   logic [43:0]        x_ff, x_in, r_ff, r_in, bit_ff, bit_in;
   logic               which_ff, which_in;
   logic [20:0]        rd_ff, rd_in, rs_ff, rs_in;
   logic [59:0]        rem_ff, rem_in, dsh_ff, dsh_in;
   logic [17:0]        q_ff, q_in;
   logic [4:0]         dcnt_ff, dcnt_in;
   logic signed [COS_BITS-1:0] cos_ff, cos_in;

   logic signed [21:0] mul_a, mul_b;
   logic signed [43:0] mul_p;
   logic [43:0]        sq_t;
   logic [32:0]        abs_d [3], abs_s [3];
   logic [42:0]        dot_abs;
   logic [17:0]        q_next;
   logic [59:0]        rem_sub;

   function automatic logic [32:0] abs34(input logic signed [33:0] v);
      logic signed [33:0] n;
      n = -v;
      return v[33] ? n[32:0] : v[32:0];
   endfunction

   function automatic logic [32:0] max3(input logic [32:0] a, input logic [32:0] b,
                                         input logic [32:0] c);
      logic [32:0] m;
      m = (a > b) ? a : b;
      return (c > m) ? c : m;
   endfunction

   // shared multiplier
   assign mul_p = mul_a * mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == C_DEN) begin
         mul_a = {1'b0, rd_ff};
         mul_b = {1'b0, rs_ff};
      end else begin
         case (phase_ff)
            2'd0: begin
               mul_a = dv_ff[lane_ff][21:0];
               mul_b = sv_ff[lane_ff][21:0];
            end
            2'd1: begin
               mul_a = dv_ff[lane_ff][21:0];
               mul_b = dv_ff[lane_ff][21:0];
            end
            default: begin
               mul_a = sv_ff[lane_ff][21:0];
               mul_b = sv_ff[lane_ff][21:0];
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_d[i] = abs34(dv_ff[i]);
         abs_s[i] = abs34(sv_ff[i]);
      end
      sq_t    = r_ff + bit_ff;
      dot_abs = dot_ff[43] ? 43'(-dot_ff) : dot_ff[42:0];
      rem_sub = rem_ff - dsh_ff;
      q_next  = {q_ff[16:0], (rem_ff >= dsh_ff)};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      dv_in    = dv_ff;
      sv_in    = sv_ff;
      md_in    = md_ff;
      ms_in    = ms_ff;
      phase_in = phase_ff;
      lane_in  = lane_ff;
      prod_in  = prod_ff;
      dot_in   = dot_ff;
      dd_in    = dd_ff;
      ss_in    = ss_ff;
      x_in     = x_ff;
      r_in     = r_ff;
      bit_in   = bit_ff;
      which_in = which_ff;
      rd_in    = rd_ff;
      rs_in    = rs_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      dcnt_in  = dcnt_ff;
      cos_in   = cos_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               dv_in[0] = 34'(req.neighbour_x) - 34'(req.owner_x);
               dv_in[1] = 34'(req.neighbour_y) - 34'(req.owner_y);
               dv_in[2] = 34'(req.neighbour_z) - 34'(req.owner_z);
               sv_in[0] = 34'(req.area_x);
               sv_in[1] = 34'(req.area_y);
               sv_in[2] = 34'(req.area_z);
               state_in = C_MAX;
            end
         end
         C_MAX: begin
            md_in = max3(abs_d[0], abs_d[1], abs_d[2]);
            ms_in = max3(abs_s[0], abs_s[1], abs_s[2]);
            if (md_in == '0 || ms_in == '0) begin
               cos_in   = '0;
               state_in = C_DONE;
            end else begin
               state_in = C_SCALE;
            end
         end
         C_SCALE: begin
            // walk each vector one bit a cycle into [2^19, 2^20)
            if (md_ff[32:20] != '0) begin
               md_in = md_ff >> 1;
               for (int i = 0; i < 3; i++) dv_in[i] = dv_ff[i] >>> 1;
            end else if (!md_ff[19]) begin
               md_in = md_ff << 1;
               for (int i = 0; i < 3; i++) dv_in[i] = dv_ff[i] <<< 1;
            end
            if (ms_ff[32:20] != '0) begin
               ms_in = ms_ff >> 1;
               for (int i = 0; i < 3; i++) sv_in[i] = sv_ff[i] >>> 1;
            end else if (!ms_ff[19]) begin
               ms_in = ms_ff << 1;
               for (int i = 0; i < 3; i++) sv_in[i] = sv_ff[i] <<< 1;
            end
            if (md_ff[32:20] == '0 && md_ff[19] && ms_ff[32:20] == '0 && ms_ff[19]) begin
               phase_in = 2'd0;
               lane_in  = 2'd0;
               dot_in   = '0;
               dd_in    = '0;
               ss_in    = '0;
               state_in = C_MUL;
            end
         end
         C_MUL: begin
            prod_in  = mul_p;
            state_in = C_ACC;
         end
         C_ACC: begin
            case (phase_ff)
               2'd0:    dot_in = dot_ff + prod_ff;
               2'd1:    dd_in  = dd_ff + $unsigned(prod_ff);
               default: ss_in  = ss_ff + $unsigned(prod_ff);
            endcase
            state_in = C_MUL;
            if (lane_ff == 2'd2) begin
               lane_in  = 2'd0;
               phase_in = phase_ff + 2'd1;
               if (phase_ff == 2'd2) begin
                  x_in     = dd_ff;
                  r_in     = '0;
                  bit_in   = SQRT_TOP;
                  which_in = 1'b0;
                  state_in = C_SQRT;
               end
            end else begin
               lane_in = lane_ff + 2'd1;
            end
         end
         C_SQRT: begin
            // one digit of the square root per cycle
            if (x_ff >= sq_t) begin
               x_in = x_ff - sq_t;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == 44'd1) begin
               if (!which_ff) begin
                  rd_in    = r_in[20:0];
                  x_in     = ss_ff;
                  r_in     = '0;
                  bit_in   = SQRT_TOP;
                  which_in = 1'b1;
               end else begin
                  rs_in    = r_in[20:0];
                  state_in = C_DEN;
               end
            end
         end
         C_DEN: begin
            prod_in  = mul_p;
            state_in = C_DIVI;
         end
         C_DIVI: begin
            if (prod_ff == '0) begin
               cos_in   = '0;
               state_in = C_DONE;
            end else begin
               rem_in   = {2'b0, dot_abs, 15'b0} + 60'(prod_ff[42:1]);
               dsh_in   = {1'b0, prod_ff[41:0], 17'b0};
               q_in     = '0;
               dcnt_in  = '0;
               state_in = C_DIV;
            end
         end
         C_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (rem_ff >= dsh_ff) rem_in = rem_sub;
            dsh_in  = dsh_ff >> 1;
            q_in    = q_next;
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd17) begin
               if (dot_ff[43]) begin
                  cos_in = (q_next >= 18'd32768) ? -16'sd32768 : 16'(~q_next[15:0] + 16'd1);
               end else begin
                  cos_in = (q_next >= 18'd32767) ? COS_MAX : $signed(q_next[15:0]);
               end
               state_in = C_DONE;
            end
         end
         C_DONE: begin
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dv_ff    <= dv_in;
      sv_ff    <= sv_in;
      md_ff    <= md_in;
      ms_ff    <= ms_in;
      phase_ff <= phase_in;
      lane_ff  <= lane_in;
      prod_ff  <= prod_in;
      dot_ff   <= dot_in;
      dd_ff    <= dd_in;
      ss_ff    <= ss_in;
      x_ff     <= x_in;
      r_ff     <= r_in;
      bit_ff   <= bit_in;
      which_ff <= which_in;
      rd_ff    <= rd_in;
      rs_ff    <= rs_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      q_ff     <= q_in;
      dcnt_ff  <= dcnt_in;
      cos_ff   <= cos_in;
   end

   assign done   = (state_ff == C_DONE);
   assign cosine = cos_ff;

endmodule

// ===== src/mfoc_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfoc_stats
// Binning, classing and running totals of face cosines.
// ----------------------------------------------------------------------------
module mfoc_stats
   import mfoc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       update,
   input  logic                       clear,
   input  logic signed [COS_BITS-1:0] cosine,
   input  logic signed [COS_BITS-1:0] severe_thr,
   input  logic signed [COS_BITS-1:0] error_lvl,
   input  logic [BIN_BITS-1:0]        rd_index,
   output logic [BIN_BITS-1:0]        face_bin,
   output logic [1:0]                 face_class,
   output logic [FACE_COUNT_BITS-1:0] face_no,
   output logic [CNT_BITS-1:0]        rd_count,
   output mfoc_totals_type            totals
);

   logic [CNT_BITS-1:0]        bin_ff [NUM_BINS];
   logic signed [COS_BITS-1:0] min_ff;
   logic signed [SUM_BITS-1:0] sum_ff;
   logic [CNT_BITS-1:0]        sev_ff, err_ff, face_ff;
   logic                       found;

   // first bin whose edges hold the cosine
   always_comb begin
      face_bin = BIN_BITS'(NUM_BINS);
      found    = 1'b0;
      for (int i = 0; i < NUM_BINS && i < 18; i++) begin
         if (!found && BIN_EDGE[i+1] <= cosine && cosine <= BIN_EDGE[i]) begin
            face_bin = BIN_BITS'(i);
            found    = 1'b1;
         end
      end
   end

   always_comb begin
      if (cosine >= severe_thr)     face_class = CLASS_OK;
      else if (cosine > error_lvl) face_class = CLASS_SEVERE;
      else                         face_class = CLASS_ERROR;
   end

   assign face_no  = face_ff[FACE_COUNT_BITS-1:0];
   assign rd_count = (rd_index < BIN_BITS'(NUM_BINS)) ? bin_ff[rd_index] : '0;
   assign totals   = '{face_count: face_ff, min_cosine: min_ff, sum_cosine: sum_ff,
                       severe_count: sev_ff, error_count: err_ff};

   // accumulate on each face, drop everything after the mesh totals
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < NUM_BINS; i++) bin_ff[i] <= '0;
         min_ff  <= COS_MAX;
         sum_ff  <= '0;
         sev_ff  <= '0;
         err_ff  <= '0;
         face_ff <= '0;
      end else if (update) begin
         if (found) bin_ff[face_bin] <= bin_ff[face_bin] + 1'b1;
         if (face_class == CLASS_SEVERE) sev_ff <= sev_ff + 1'b1;
         if (face_class == CLASS_ERROR)  err_ff <= err_ff + 1'b1;
         if (cosine < min_ff) min_ff <= cosine;
         sum_ff  <= sum_ff + SUM_BITS'(cosine);
         face_ff <= face_ff + 1'b1;
      end
   end

endmodule

// ===== src/mesh_face_orthogonality_check_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_face_orthogonality_check_top
// Face cosine check with 10-degree histogram and mesh totals.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    mfoc_req_type, one face
//  rsp      out        rsp_valid/stall    mfoc_rsp_type, one result
//  csr      in         csr_valid/ready    csr_index, csr_data
//
//  A face passes through the cosine unit in order: the one-bit-a-cycle
//  scaling walk, the products on the shared multiplier, square root
//  digits for both vectors and the divide, then a done state;
//  a zero vector goes straight from the max step to the done state.
//  req_stall stays high from acceptance until the last result has gone; a
//  final face adds nine bin transfers and one totals transfer, then clears.
//  Reset is synchronous and needs no clearing pass; rsp_stall only holds output.
// ----------------------------------------------------------------------------
module mesh_face_orthogonality_check_top
   import mfoc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mfoc_req_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mfoc_rsp_type              rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [COS_BITS-1:0]       csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CALC  = 3'd1;
   localparam logic [2:0] ST_FACE  = 3'd2;
   localparam logic [2:0] ST_BINS  = 3'd3;
   localparam logic [2:0] ST_TOTAL = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic                       last_ff, last_in;
   logic [BIN_BITS-1:0]        idx_ff, idx_in;
   mfoc_rsp_type               rsp_ff, rsp_in;
   logic signed [COS_BITS-1:0] thr_ff, lvl_ff;

   logic                       req_xfer, rsp_xfer, cos_done, stats_clear;
   logic signed [COS_BITS-1:0] cos_val;
   logic [BIN_BITS-1:0]        face_bin, rd_index;
   logic [1:0]                 face_class;
   logic [FACE_COUNT_BITS-1:0] face_no;
   logic [CNT_BITS-1:0]        rd_count;
   mfoc_totals_type            totals;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_xfer    = req_valid && !req_stall;
   assign rsp_valid   = (state_ff == ST_FACE) || (state_ff == ST_BINS) ||
                        (state_ff == ST_TOTAL);
   assign rsp_xfer    = rsp_valid && !rsp_stall;
   assign rsp_data    = rsp_ff;
   assign csr_ready   = 1'b1;
   assign stats_clear = (state_ff == ST_TOTAL) && rsp_xfer;
   assign rd_index    = (state_ff == ST_BINS) ? idx_ff + 1'b1 : '0;

   mfoc_cosine u_cosine (
      .clock  (clock),
      .reset  (reset),
      .start  (req_xfer),
      .req    (req_data),
      .done   (cos_done),
      .cosine (cos_val)
   );

   mfoc_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .update     (cos_done),
      .clear      (stats_clear),
      .cosine     (cos_val),
      .severe_thr (thr_ff),
      .error_lvl  (lvl_ff),
      .rd_index   (rd_index),
      .face_bin   (face_bin),
      .face_class (face_class),
      .face_no    (face_no),
      .rd_count   (rd_count),
      .totals     (totals)
   );

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= SEVERE_THR_RESET;
         lvl_ff <= ERROR_LVL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SEVERE_THR: thr_ff <= $signed(csr_data);
            CSR_ERROR_LVL:  lvl_ff <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // sequence results: face, then bins and totals on the final face
   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      rsp_in   = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               last_in  = req_data.last_face;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (cos_done) begin
               rsp_in             = '0;
               rsp_in.result_kind = KIND_FACE;
               rsp_in.item_index  = face_no;
               rsp_in.cosine      = cos_val;
               rsp_in.bin_number  = face_bin;
               rsp_in.face_class  = face_class;
               rsp_in.last_result = !last_ff;
               state_in           = ST_FACE;
            end
         end
         ST_FACE: begin
            if (rsp_xfer) begin
               if (last_ff) begin
                  rsp_in             = '0;
                  rsp_in.result_kind = KIND_BIN;
                  rsp_in.count       = rd_count;
                  idx_in             = '0;
                  state_in           = ST_BINS;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_BINS: begin
            if (rsp_xfer) begin
               rsp_in = '0;
               if (idx_ff == BIN_BITS'(NUM_BINS - 1)) begin
                  rsp_in.result_kind  = KIND_TOTAL;
                  rsp_in.count        = totals.face_count;
                  rsp_in.min_cosine   = totals.min_cosine;
                  rsp_in.sum_cosine   = totals.sum_cosine;
                  rsp_in.severe_count = totals.severe_count;
                  rsp_in.error_count  = totals.error_count;
                  rsp_in.any_error    = (totals.error_count != '0);
                  rsp_in.last_result  = 1'b1;
                  state_in            = ST_TOTAL;
               end else begin
                  rsp_in.result_kind = KIND_BIN;
                  rsp_in.item_index  = FACE_COUNT_BITS'(rd_index);
                  rsp_in.count       = rd_count;
                  idx_in             = idx_ff + 1'b1;
               end
            end
         end
         ST_TOTAL: begin
            if (rsp_xfer) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // no new face while results are still pending
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> !rsp_valid)
      else $error("face accepted while results pending");

   // totals always close an item
   a_total_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == KIND_TOTAL) |-> rsp_data.last_result)
      else $error("totals without last_result");

   // nothing follows the final result of an item
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_data.last_result) |=> !rsp_valid)
      else $error("result after last_result");

   // bin results only carry real bin numbers
   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == KIND_BIN) |->
         (rsp_data.item_index < FACE_COUNT_BITS'(NUM_BINS)))
      else $error("bin index out of range");

endmodule

// ===== tb/tb_mesh_face_orthogonality_check_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mesh_face_orthogonality_check_top
// Self-checking bench for the face orthogonality check. Faces are driven from
// a short directed table, then from random meshes under four idling phases.
// A behavioural predictor scores each face and builds the bin counts and
// totals of a mesh. Every result transfer is compared field by field.
// ----------------------------------------------------------------------------
module tb_mesh_face_orthogonality_check_top;
   import mfoc_pkg::*;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   mfoc_req_type            req_data;
   logic                    rsp_valid;
   logic                    rsp_stall;
   mfoc_rsp_type            rsp_data;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [COS_BITS-1:0]     csr_data;

   mesh_face_orthogonality_check_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   logic signed [15:0] thr_severe;
   logic signed [15:0] lvl_error;
   logic [24:0]        hist_bins [0:NUM_BINS-1];
   logic signed [15:0] low_cos;
   logic [39:0]        cos_total;
   logic [24:0]        n_severe;
   logic [24:0]        n_error;
   logic [24:0]        n_faces;

   mfoc_rsp_type pending_results [$];
   int n_mismatch;
   int n_checked;
   int n_faces_sent;
   int n_meshes;
   int sender_idle_pct;
   int receiver_stall_pct;

   // directed rows: face plus an optional typed-in expected cosine and class
   typedef struct {
      mfoc_req_type face;
      bit           known;
      logic signed [15:0] cos_exp;
      logic [1:0]   class_exp;
   } face_row_type;
   face_row_type directed_rows [$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
   end

   // clear mesh accumulators
   task automatic clear_mesh();
      for (int i = 0; i < NUM_BINS; i++) hist_bins[i] = '0;
      low_cos   = COS_MAX;
      cos_total = '0;
      n_severe  = '0;
      n_error   = '0;
      n_faces   = '0;
   endtask

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   // normalise so the largest component lies in [2^19, 2^20)
   function automatic bit normalise(inout longint v [3]);
      longint m;
      int     n;
      m = mag(v[0]);
      if (mag(v[1]) > m) m = mag(v[1]);
      if (mag(v[2]) > m) m = mag(v[2]);
      if (m == 0) return 0;
      n = 0;
      while (m != 0) begin
         n++;
         m = m >>> 1;
      end
      for (int i = 0; i < 3; i++)
         if (n > 20) v[i] = v[i] >>> (n - 20);
         else v[i] = v[i] * (longint'(1) << (20 - n));
      return 1;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] face_cos(mfoc_req_type f);
      longint d [3];
      longint s [3];
      longint dot;
      longint unsigned den, num, q;
      d[0] = longint'(f.neighbour_x) - longint'(f.owner_x);
      d[1] = longint'(f.neighbour_y) - longint'(f.owner_y);
      d[2] = longint'(f.neighbour_z) - longint'(f.owner_z);
      s[0] = f.area_x;
      s[1] = f.area_y;
      s[2] = f.area_z;
      if (!normalise(d) || !normalise(s)) return 16'sd0;
      dot = d[0] * s[0] + d[1] * s[1] + d[2] * s[2];
      den = root_floor(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]) *
            root_floor(s[0] * s[0] + s[1] * s[1] + s[2] * s[2]);
      if (den == 0) return 16'sd0;
      num = longint'(mag(dot)) << 15;
      q = (num + den / 2) / den;
      if (dot < 0) return q >= 32768 ? -16'sd32768 : -16'(q);
      return q >= 32767 ? 16'sd32767 : 16'(q);
   endfunction

   // score one face and queue what the block should return for it
   task automatic predict_face(mfoc_req_type f);
      mfoc_rsp_type r;
      logic signed [15:0] c;
      int b;
      c = face_cos(f);
      b = NUM_BINS;
      for (int i = 0; i < NUM_BINS; i++)
         if (BIN_EDGE[i+1] <= c && c <= BIN_EDGE[i]) begin
            b = i;
            break;
         end
      r = '0;
      r.result_kind = KIND_FACE;
      r.item_index  = n_faces[FACE_COUNT_BITS-1:0];
      r.cosine      = c;
      r.bin_number  = BIN_BITS'(b);
      r.face_class  = CLASS_OK;
      r.last_result = !f.last_face;
      if (b < NUM_BINS) hist_bins[b] = hist_bins[b] + 1'b1;
      if (c < thr_severe) begin
         if (c > lvl_error) begin
            r.face_class = CLASS_SEVERE;
            n_severe = n_severe + 1'b1;
         end else begin
            r.face_class = CLASS_ERROR;
            n_error = n_error + 1'b1;
         end
      end
      if (c < low_cos) low_cos = c;
      cos_total = cos_total + 40'(c);
      n_faces = n_faces + 1'b1;
      pending_results.push_back(r);
      if (f.last_face) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            r = '0;
            r.result_kind = KIND_BIN;
            r.item_index  = FACE_COUNT_BITS'(i);
            r.count       = hist_bins[i];
            pending_results.push_back(r);
         end
         r = '0;
         r.result_kind  = KIND_TOTAL;
         r.count        = n_faces;
         r.min_cosine   = low_cos;
         r.sum_cosine   = cos_total;
         r.severe_count = n_severe;
         r.error_count  = n_error;
         r.any_error    = n_error != 0;
         r.last_result  = 1'b1;
         pending_results.push_back(r);
         clear_mesh();
         n_meshes++;
      end
   endtask

   task automatic report(string what, mfoc_rsp_type e, mfoc_rsp_type a);
      n_mismatch++;
      if (n_mismatch <= 10)
         $display("mismatch %s: expected %p actual %p", what, e, a);
   endtask

   // score result transfers
   always @(posedge clock) begin
      mfoc_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report("unexpected result", '0, rsp_data);
         end else begin
            e = pending_results.pop_front();
            n_checked++;
            if (rsp_data.result_kind !== e.result_kind ||
                rsp_data.item_index !== e.item_index ||
                rsp_data.cosine !== e.cosine ||
                rsp_data.bin_number !== e.bin_number ||
                rsp_data.face_class !== e.face_class ||
                rsp_data.count !== e.count ||
                rsp_data.min_cosine !== e.min_cosine ||
                rsp_data.sum_cosine !== e.sum_cosine ||
                rsp_data.severe_count !== e.severe_count ||
                rsp_data.error_count !== e.error_count ||
                rsp_data.any_error !== e.any_error ||
                rsp_data.last_result !== e.last_result)
               report("field", e, rsp_data);
         end
      end
   end

   // receiver stalls
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic signed [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SEVERE_THR) thr_severe = v;
      else if (idx == CSR_ERROR_LVL) lvl_error = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one face transfer, with sender idling beforehand
   task automatic send_face(mfoc_req_type f);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= f;
      do @(posedge clock); while (req_stall);
      predict_face(f);
      n_faces_sent++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rnd_coord();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return $signed(32'($urandom_range(2000))) - 1000;
         2:       return $signed($urandom) >>> $urandom_range(24);
         default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      endcase
   endfunction

   // mostly near-aligned faces so every bin and class is reached
   function automatic mfoc_req_type rnd_face(bit last);
      mfoc_req_type f;
      f.owner_x = rnd_coord();
      f.owner_y = rnd_coord();
      f.owner_z = rnd_coord();
      if ($urandom_range(99) < 70) begin
         f.neighbour_x = f.owner_x + ($signed(32'($urandom_range(65535))) - 32768);
         f.neighbour_y = f.owner_y + ($signed(32'($urandom_range(65535))) - 32768);
         f.neighbour_z = f.owner_z + ($signed(32'($urandom_range(65535))) - 32768);
         f.area_x = (f.neighbour_x - f.owner_x) * $signed(32'($urandom_range(4) + 1))
                    + ($signed(32'($urandom_range(40000))) - 20000);
         f.area_y = (f.neighbour_y - f.owner_y) + ($signed(32'($urandom_range(40000))) - 20000);
         f.area_z = (f.neighbour_z - f.owner_z) + ($signed(32'($urandom_range(40000))) - 20000);
      end else begin
         f.neighbour_x = rnd_coord();
         f.neighbour_y = rnd_coord();
         f.neighbour_z = rnd_coord();
         f.area_x = rnd_coord();
         f.area_y = rnd_coord();
         f.area_z = rnd_coord();
      end
      f.last_face = last;
      return f;
   endfunction

   function automatic face_row_type mk_row(logic signed [31:0] ox, logic signed [31:0] nx,
                                           logic signed [31:0] ny, logic signed [31:0] ax,
                                           logic signed [31:0] ay, bit last, bit known,
                                           logic signed [15:0] c, logic [1:0] k);
      face_row_type r;
      r.face = '0;
      r.face.owner_x = ox;
      r.face.neighbour_x = nx;
      r.face.neighbour_y = ny;
      r.face.area_x = ax;
      r.face.area_y = ay;
      r.face.last_face = last;
      r.known = known;
      r.cos_exp = c;
      r.class_exp = k;
      return r;
   endfunction

   initial begin
      mfoc_req_type f;
      mfoc_rsp_type e;
      int phase_len;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SEVERE_THR;
      csr_data = '0;
      n_mismatch = 0;
      n_checked = 0;
      n_faces_sent = 0;
      n_meshes = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      thr_severe = SEVERE_THR_RESET;
      lvl_error = ERROR_LVL_RESET;
      clear_mesh();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table: aligned, opposed, perpendicular, zero vectors, extremes
      directed_rows.push_back(mk_row(0, 32'h10000, 0, 32'h10000, 0, 0, 1, 16'sd32767, CLASS_OK));
      directed_rows.push_back(mk_row(0, 32'h10000, 0, -32'h10000, 0, 0, 1, -16'sd32768,
                                     CLASS_ERROR));
      directed_rows.push_back(mk_row(0, 32'h10000, 0, 0, 32'h10000, 0, 1, 16'sd0, CLASS_ERROR));
      directed_rows.push_back(mk_row(5, 5, 0, 32'h10000, 0, 0, 1, 16'sd0, CLASS_ERROR));
      directed_rows.push_back(mk_row(0, 32'h10000, 0, 0, 0, 0, 1, 16'sd0, CLASS_ERROR));
      directed_rows.push_back(mk_row(32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                     32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(32'h7fffffff, 32'h80000000, 32'h80000000,
                                     32'h80000000, 32'h7fffffff, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(0, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(0, 32'h10000, 32'h30000, 32'h10000, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(0, 1, 1, -1, 1, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(0, 32'h10000, 32'h8000, 32'h10000, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(0, 32'h10000, -32'h20000, 32'h10000, 0, 1, 0, 0, 0));
      foreach (directed_rows[i]) begin
         send_face(directed_rows[i].face);
         if (directed_rows[i].known) begin
            // score the block against the typed-in cosine and class
            f = directed_rows[i].face;
            if (face_cos(f) !== directed_rows[i].cos_exp) begin
               n_mismatch++;
               $display("directed row %0d: predictor cosine disagrees", i);
            end
            e = pending_results.pop_back();
            e.cosine     = directed_rows[i].cos_exp;
            e.face_class = directed_rows[i].class_exp;
            pending_results.push_back(e);
         end
      end
      drain();

      // register settings, extremes included, then random meshes under each idling phase
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               sender_idle_pct = 0; receiver_stall_pct = 0;
               write_reg(CSR_SEVERE_THR, 16'sd32767);
               write_reg(CSR_ERROR_LVL, -16'sd32768);
            end
            1: begin
               sender_idle_pct = 73; receiver_stall_pct = 0;
               write_reg(CSR_SEVERE_THR, -16'sd32768);
               write_reg(CSR_ERROR_LVL, 16'sd32767);
            end
            2: begin
               sender_idle_pct = 0; receiver_stall_pct = 73;
               write_reg(CSR_SEVERE_THR, 16'sd28378);
               write_reg(CSR_ERROR_LVL, 16'sd16384);
            end
            default: begin
               sender_idle_pct = 30; receiver_stall_pct = 30;
               write_reg(CSR_SEVERE_THR, SEVERE_THR_RESET);
               write_reg(CSR_ERROR_LVL, ERROR_LVL_RESET);
            end
         endcase
         phase_len = 40;
         for (int i = 0; i < phase_len; i++) begin
            send_face(rnd_face(i == phase_len - 1 || $urandom_range(99) < 8));
            // hold off once until the block has caught up
            if (ph == 1 && i == 10)
               while (pending_results.size() != 0) @(posedge clock);
         end
         drain();
      end

      $display("covered %0d faces in %0d meshes, %0d results checked",
               n_faces_sent, n_meshes, n_checked);
      if (n_mismatch == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", n_mismatch, pending_results.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
